[src/jcfs_pkg.sv]
// Types and constants shared by the comment fragment scanner.
// Result record, per-step result bundle, role codes and delimiter byte values.
// No dependencies.
`timescale 1ns / 1ps

package jcfs_pkg;

    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_BTICK = 8'h60;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_DQ    = 8'h22;

    // result queue entries; power of two, at least 2
    localparam int OUT_DEPTH = 4;

    typedef enum logic [1:0] {
        ROLE_CODE  = 2'd0,
        ROLE_DELIM = 2'd1,
        ROLE_TEXT  = 2'd2
    } role_t;

    // one classified byte
    typedef struct packed {
        logic [7:0] char_out;
        role_t      role;
        logic       fragment_end;
        logic       line_end;
        logic       run_last;
    } res_t;

    // results produced by one step, in byte order
    typedef struct packed {
        logic [1:0] count;
        res_t       r0;
        res_t       r1;
    } step_out_t;

endpackage

[src/jcfs_core.sv]
// Scanner state and per-byte classification step.
// Holds the lookahead byte and the quote/comment flags; emits up to two results a step.
// Depends on jcfs_pkg.
`timescale 1ns / 1ps

module jcfs_core import jcfs_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance,
    input  logic [7:0] char_in,
    input  logic       line_last,
    output step_out_t  step_out
);

    localparam logic [1:0] Q_NONE   = 2'd0;
    localparam logic [1:0] Q_SINGLE = 2'd1;
    localparam logic [1:0] Q_DOUBLE = 2'd2;
    localparam logic [1:0] Q_TMPL   = 2'd3;

    typedef enum logic [1:0] {
        PK_NONE  = 2'd0,
        PK_CLOSE = 2'd1,
        PK_LINE  = 2'd2,
        PK_OPEN  = 2'd3
    } pair_t;

    typedef struct packed {
        logic       in_block;
        logic       in_line_comment;
        logic [1:0] quote_state;
        logic       escape_pending;
        logic       block_text_seen;
    } st_t;

    typedef struct packed {
        st_t   st;
        role_t role;
    } cls_t;

    function automatic logic [1:0] toggle_quote(logic [1:0] qs, logic [1:0] kind);
        return (qs != Q_NONE) ? Q_NONE : kind;
    endfunction

    function automatic cls_t classify(st_t s, logic [7:0] x);
        cls_t r;
        r.st   = s;
        r.role = ROLE_CODE;
        if (s.in_line_comment) begin
            r.role = ROLE_TEXT;
        end else if (s.in_block) begin
            r.st.block_text_seen = 1'b1;
            r.role = ROLE_TEXT;
        end else if (s.escape_pending) begin
            r.st.escape_pending = 1'b0;
        end else if (s.quote_state != Q_NONE && x == CH_BSL) begin
            r.st.escape_pending = 1'b1;
        end else if (x == CH_SQ && (s.quote_state == Q_NONE || s.quote_state == Q_SINGLE)) begin
            r.st.quote_state = toggle_quote(s.quote_state, Q_SINGLE);
        end else if (x == CH_DQ && (s.quote_state == Q_NONE || s.quote_state == Q_DOUBLE)) begin
            r.st.quote_state = toggle_quote(s.quote_state, Q_DOUBLE);
        end else if (x == CH_BTICK && (s.quote_state == Q_NONE || s.quote_state == Q_TMPL)) begin
            r.st.quote_state = toggle_quote(s.quote_state, Q_TMPL);
        end
        return r;
    endfunction

    function automatic pair_t pair_kind(st_t s, logic [7:0] h, logic [7:0] c);
        pair_t pk;
        pk = PK_NONE;
        if (s.in_block) begin
            if (h == CH_STAR && c == CH_SLASH) pk = PK_CLOSE;
        end else if (!s.in_line_comment && !s.escape_pending && s.quote_state == Q_NONE
                     && h == CH_SLASH) begin
            if (c == CH_SLASH) pk = PK_LINE;
            else if (c == CH_STAR) pk = PK_OPEN;
        end
        return pk;
    endfunction

    st_t        state_reg, state_next;
    logic       held_valid_reg, held_valid_next;
    logic [7:0] held_byte_reg, held_byte_next;

    always_comb begin
        cls_t      ca;
        cls_t      cb;
        pair_t     pk;
        step_out_t so;
        st_t       s;
        s               = state_reg;
        held_valid_next = held_valid_reg;
        held_byte_next  = held_byte_reg;
        so              = '0;
        ca              = '0;
        cb              = '0;
        pk              = PK_NONE;

        if (held_valid_reg) begin
            pk = pair_kind(s, held_byte_reg, char_in);
            held_valid_next = 1'b0;
            if (pk != PK_NONE) begin
                case (pk)
                    PK_CLOSE: begin
                        s.in_block = 1'b0;
                        s.block_text_seen = 1'b0;
                    end
                    PK_LINE: s.in_line_comment = 1'b1;
                    PK_OPEN: begin
                        s.in_block = 1'b1;
                        s.block_text_seen = 1'b0;
                    end
                    default: s = s;
                endcase
                so.r0 = '{held_byte_reg, ROLE_DELIM, 1'b0, 1'b0, 1'b0};
                so.r1 = '{char_in, ROLE_DELIM, (pk == PK_CLOSE), line_last, 1'b0};
                so.count = 2'd2;
            end else begin
                ca = classify(s, held_byte_reg);
                s = ca.st;
                so.r0 = '{held_byte_reg, ca.role, 1'b0, 1'b0, 1'b0};
                so.count = 2'd1;
                if (line_last) begin
                    cb = classify(s, char_in);
                    s = cb.st;
                    so.r1 = '{char_in, cb.role, 1'b0, 1'b1, 1'b0};
                    so.count = 2'd2;
                end else begin
                    held_byte_next  = char_in;
                    held_valid_next = 1'b1;
                end
            end
        end else if (line_last) begin
            ca = classify(s, char_in);
            s = ca.st;
            so.r0 = '{char_in, ca.role, 1'b0, 1'b1, 1'b0};
            so.count = 2'd1;
        end else begin
            held_byte_next  = char_in;
            held_valid_next = 1'b1;
        end

        if (line_last) begin
            // fragment closes at line end for a line comment or a block with text seen
            if (s.in_line_comment || (s.in_block && s.block_text_seen)) begin
                if (so.count == 2'd2) so.r1.fragment_end = 1'b1;
                else if (so.count == 2'd1) so.r0.fragment_end = 1'b1;
            end
            s.in_line_comment = 1'b0;
            s.quote_state     = Q_NONE;
            s.escape_pending  = 1'b0;
            s.block_text_seen = 1'b0;
            held_valid_next   = 1'b0;
        end

        if (so.count == 2'd2) so.r1.run_last = 1'b1;
        else if (so.count == 2'd1) so.r0.run_last = 1'b1;

        state_next = s;
        step_out   = so;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= '0;
            held_valid_reg <= 1'b0;
        end else if (advance) begin
            state_reg      <= state_next;
            held_valid_reg <= held_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) held_byte_reg <= held_byte_next;
    end

endmodule

[src/jcfs_out_fifo.sv]
// Result queue: takes up to two results per cycle, delivers one per transfer.
// Register file with read/write pointers and an occupancy count.
// Depends on jcfs_pkg.
`timescale 1ns / 1ps

module jcfs_out_fifo import jcfs_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  step_out_t push_data,
    input  logic      pop,
    output logic      room2,
    output logic      not_empty,
    output res_t      head
);

    localparam int DEPTH = OUT_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    res_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] push_n;
    logic [PTR_W-1:0] wr_ptr_p1;

    assign push_n    = push ? CNT_W'(push_data.count) : '0;
    assign cnt_next  = cnt_reg + push_n - CNT_W'(pop);
    assign wr_ptr_p1 = wr_ptr_reg + PTR_W'(1);
    assign room2     = (cnt_reg <= CNT_W'(DEPTH - 2));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_n);
            if (pop) rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push && push_data.count != 2'd0) mem_reg[wr_ptr_reg] <= push_data.r0;
        if (push && push_data.count == 2'd2) mem_reg[wr_ptr_p1] <= push_data.r1;
    end

endmodule

[src/js_comment_fragment_scanner_top.sv]
// An input byte is registered, classified and written into the result queue, whose
// head is offered at the output; a byte held in the lookahead register is written with
// the next byte of its line. Input stalls without queue room; output waits on m_tready.
// Throughput: one byte per cycle; a step may queue two results, drained one per cycle
// through an OUT_DEPTH-entry result queue that must keep room for two.
// Reset: synchronous active-low aresetn clears scanner flags, lookahead and queue.
`timescale 1ns / 1ps

module js_comment_fragment_scanner_top import jcfs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_in
    input  logic        s_tlast,   // line_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] char_out, [8] fragment_end, [9] line_end
    output logic [1:0]  m_tuser,   // [1:0] role
    output logic        m_tlast    // run_last
);

    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       in_last_reg;
    logic       advance;
    logic       room2;
    logic       not_empty;
    step_out_t  step_out;
    res_t       head;

    assign advance  = in_valid_reg && room2;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    jcfs_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .char_in   (in_char_reg),
        .line_last (in_last_reg),
        .step_out  (step_out)
    );

    jcfs_out_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (advance),
        .push_data (step_out),
        .pop       (m_tvalid && m_tready),
        .room2     (room2),
        .not_empty (not_empty),
        .head      (head)
    );

    assign m_tvalid = not_empty;
    assign m_tdata  = {6'd0, head.line_end, head.fragment_end, head.char_out};
    assign m_tuser  = head.role;
    assign m_tlast  = head.run_last;

endmodule

[src/jcfs_checker.sv]
// Port-level checks for the comment fragment scanner, bound to the top level.
// Depends on jcfs_pkg.
`timescale 1ns / 1ps

module jcfs_checker import jcfs_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // a stalled result transfer keeps its content
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed while stalled");

    // queue is empty right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_role_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser != 2'd3)
        else $error("undefined role");

    // a fragment only closes on a comment byte
    a_frag_role: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[8] |-> m_tuser == ROLE_DELIM || m_tuser == ROLE_TEXT)
        else $error("fragment end on code byte");

    // the last byte of a line is always the last result of its step
    a_line_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[9] |-> m_tlast)
        else $error("line end without run last");

endmodule

bind js_comment_fragment_scanner_top jcfs_checker u_jcfs_checker (.*);
